@@ rtl/core/hextile_rect_decoder_core_defines.svh @@
// Assertion macros shared by the hextile decoder modules
`ifndef HEXTILE_RECT_DECODER_CORE_DEFINES_SVH
`define HEXTILE_RECT_DECODER_CORE_DEFINES_SVH
// Implication checked at every rising clock edge outside reset
`define HRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset
`define HRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/core/hrd_pkg.sv @@
//------------------------------------------------------------------------------
// hrd_pkg
// Shared types and constants of the hextile rectangle decoder.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package hrd_pkg;
	localparam int TILE_SIZE_DEF = 16;

	localparam logic [3:0] PH_SUBENC   = 4'd0;
	localparam logic [3:0] PH_BG       = 4'd1;
	localparam logic [3:0] PH_FG       = 4'd2;
	localparam logic [3:0] PH_COUNT    = 4'd3;
	localparam logic [3:0] PH_SUBCOLOR = 4'd4;
	localparam logic [3:0] PH_SUBXY    = 4'd5;
	localparam logic [3:0] PH_SUBWH    = 4'd6;
	localparam logic [3:0] PH_RAW      = 4'd7;

	localparam logic [1:0] KIND_BOX  = 2'd0;
	localparam logic [1:0] KIND_RAW  = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	localparam logic [2:0] REG_RECT_X = 3'd0;
	localparam logic [2:0] REG_RECT_Y = 3'd1;
	localparam logic [2:0] REG_RECT_W = 3'd2;
	localparam logic [2:0] REG_RECT_H = 3'd3;
	localparam logic [2:0] REG_PSIZE  = 3'd4;
	localparam logic [2:0] REG_BIGEND = 3'd5;

	// One result item
	typedef struct packed {
		logic        last;
		logic [31:0] color;
		logic [4:0]  box_h;
		logic [4:0]  box_w;
		logic [15:0] pos_y;
		logic [15:0] pos_x;
		logic [1:0]  kind;
	} result_t;

	// Up to two results caused by one byte
	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} result_pair_t;
endpackage

@@ rtl/core/hextile_rect_decoder_core.sv @@
//------------------------------------------------------------------------------
// hextile_rect_decoder_core
// Hextile rectangle decoder: one stream byte per transaction in, box fills,
// raw pixels and rectangle-done results out.
//------------------------------------------------------------------------------
// Channel | Direction | Payload
// s_axis  | in        | tdata[7:0] data_byte
// m_axis  | out       | tdata: kind, pos_x, pos_y, box_w, box_h, color; tlast = last
// cfg     | in        | cfg_index[2:0], cfg_data[15:0]
//
// One byte per cycle while s_tready is high; results are registered, then queued.
// A byte causes at most two results; the result queue holds four.
// s_tready drops only while the queue, counting the results in the result
// register, cannot take two more results.
// Reset (arst_n low) returns the tile walk to the first tile of a 1x1 rectangle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module hextile_rect_decoder_core
	import hrd_pkg::*;
#(
	parameter int TILE_SIZE = TILE_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,    // kind[1:0] pos_x[17:2] pos_y[33:18] box_w[38:34]
	                                // box_h[43:39] color[75:44] zero[79:76]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	logic         take;
	logic         res_vld;
	result_pair_t res;
	logic         space, empty;
	result_t      mr;

	// Accept a byte only with room for two results after the one in flight
	assign s_tready  = space;
	assign take      = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	hrd_parser #(.TILE_SIZE(TILE_SIZE)) u_parser (
		.clk(clk), .arst_n(arst_n),
		.byte_vld(take), .byte_in(s_tdata),
		.cfg_wr(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data),
		.res_vld(res_vld), .res(res)
	);

	hrd_out_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(res_vld), .push_data(res),
		.space(space), .empty(empty),
		.m_valid(m_tvalid), .m_ready(m_tready), .m_data(mr)
	);

	assign m_tdata = {4'd0, mr.color, mr.box_h, mr.box_w, mr.pos_y, mr.pos_x, mr.kind}
		& {80{!empty}};
	assign m_tlast = mr.last;
endmodule

@@ rtl/core/hrd_out_queue.sv @@
//------------------------------------------------------------------------------
// hrd_out_queue
// Result queue: takes a pair of results per cycle, sends one per transaction.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hextile_rect_decoder_core_defines.svh"
module hrd_out_queue
	import hrd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  result_pair_t push_data,
	output logic         space,
	output logic         empty,
	output logic         m_valid,
	input  logic         m_ready,
	output result_t      m_data
);
	localparam int DEPTH = 4;
	result_t     mem_q [DEPTH];
	logic [1:0]  wp_q, rp_q;
	logic [2:0]  cnt_q;
	logic        pop;
	logic [2:0]  n_push;

	assign pop     = m_valid && m_ready;
	assign m_valid = (cnt_q != 3'd0);
	assign m_data  = mem_q[rp_q];
	assign empty   = (cnt_q == 3'd0);
	assign n_push  = push ? (push_data.two ? 3'd2 : 3'd1) : 3'd0;
	// Room for two more results once the pending push has landed
	assign space   = ((cnt_q + n_push) <= 3'd2);

	// Store incoming results
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data.r0;
			if (push_data.two) begin
				mem_q[wp_q + 2'd1] <= push_data.r1;
			end
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + n_push[1:0];
			rp_q  <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + n_push - {2'b00, pop};
		end
	end

	`HRD_ASSERT_IMP(a_no_overflow, clk, arst_n, push, cnt_q <= 3'd2, "queue overflow")
	`HRD_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= 3'd4, "count out of range")
	`HRD_ASSERT_NEXT(a_hold, clk, arst_n, m_valid && !m_ready && !push, m_valid, "result lost")
endmodule

@@ rtl/core/hrd_parser.sv @@
//------------------------------------------------------------------------------
// hrd_parser
// Per-byte hextile parse: state update and up to two results per byte.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hextile_rect_decoder_core_defines.svh"
module hrd_parser
	import hrd_pkg::*;
#(
	parameter int TILE_SIZE = TILE_SIZE_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         byte_vld,
	input  logic [7:0]   byte_in,
	input  logic         cfg_wr,
	input  logic [2:0]   cfg_idx,
	input  logic [15:0]  cfg_val,
	output logic         res_vld,
	output result_pair_t res
);
	localparam logic [15:0] TS16 = 16'(TILE_SIZE);
	localparam logic [16:0] TS17 = 17'(TILE_SIZE);

	logic [15:0] rect_x_q, rect_y_q, rect_w_q, rect_h_q;
	logic [1:0]  psize_q;
	logic        bigend_q;
	logic [15:0] tile_x_q, tile_y_q;
	logic [4:0]  tile_w_q, tile_h_q;
	logic [4:0]  flags_q;
	logic [31:0] bg_q, fg_q, acc_q, scol_q;
	logic [7:0]  left_q, sxy_q;
	logic [3:0]  ph_q;
	logic [1:0]  bif_q;
	logic [3:0]  rcol_q, rrow_q;

	// next-state signals
	logic [15:0] tile_x_d, tile_y_d;
	logic [4:0]  tile_w_d, tile_h_d;
	logic [4:0]  flags_d;
	logic [31:0] bg_d, fg_d, acc_d, scol_d;
	logic [7:0]  left_d, sxy_d;
	logic [3:0]  ph_d;
	logic [1:0]  bif_d;
	logic [3:0]  rcol_d, rrow_d;

	logic [15:0] wv, hv, offx, offy;
	logic [16:0] endx, endy;
	logic [16:0] remx, remy;
	logic [4:0]  clipw, cliph, remw, remh;
	logic        pix_done;
	logic [31:0] pix_acc, pix_val;
	logic [1:0]  nbm1;
	logic        n_res;
	result_t     o0, o1;
	logic [1:0]  cnt;
	logic        do_end, do_bg, raw_last;
	logic [4:0]  nflags;
	logic [7:0]  left_m1;

	function automatic logic [4:0] clip5(input logic [16:0] v);
		return (v < TS17) ? v[4:0] : TS16[4:0];
	endfunction

	// Tile walk geometry
	always_comb begin
		wv    = (rect_w_q == 16'd0) ? 16'd1 : rect_w_q;
		hv    = (rect_h_q == 16'd0) ? 16'd1 : rect_h_q;
		offx  = tile_x_q - rect_x_q;
		offy  = tile_y_q - rect_y_q;
		endx  = {1'b0, offx} + TS17;
		endy  = {1'b0, offy} + TS17;
		remx  = {1'b0, wv} - endx;
		remy  = {1'b0, hv} - endy;
		clipw = clip5({1'b0, wv});
		cliph = clip5({1'b0, hv});
		remw  = clip5(remx);
		remh  = clip5(remy);
	end

	// Pixel assembly
	always_comb begin
		unique case (psize_q)
			2'd0:    nbm1 = 2'd0;
			2'd1:    nbm1 = 2'd1;
			default: nbm1 = 2'd3;
		endcase
		pix_acc = (bif_q == 2'd0) ? 32'd0 : acc_q;
		if (bigend_q) begin
			pix_acc = {pix_acc[23:0], byte_in};
		end else begin
			pix_acc = pix_acc | ({24'd0, byte_in} << {bif_q, 3'b000});
		end
		pix_done = (bif_q >= nbm1);
		unique case (nbm1)
			2'd0:    pix_val = {24'd0, pix_acc[7:0]};
			2'd1:    pix_val = {16'd0, pix_acc[15:0]};
			default: pix_val = pix_acc;
		endcase
	end

	// Parse one byte
	always_comb begin
		tile_x_d = tile_x_q; tile_y_d = tile_y_q;
		tile_w_d = tile_w_q; tile_h_d = tile_h_q;
		flags_d = flags_q; bg_d = bg_q; fg_d = fg_q; acc_d = acc_q;
		scol_d = scol_q; left_d = left_q; sxy_d = sxy_q; ph_d = ph_q;
		bif_d = bif_q; rcol_d = rcol_q; rrow_d = rrow_q;
		o0 = '0; o1 = '0; cnt = 2'd0;
		do_end = 1'b0; do_bg = 1'b0;
		nflags = byte_in[4:0];
		left_m1 = left_q - 8'd1;
		raw_last = (rcol_q == tile_w_q[3:0] - 4'd1 || tile_w_q == 5'd0 ||
			tile_w_q == 5'd1) && (rrow_q == tile_h_q[3:0] - 4'd1 ||
			tile_h_q == 5'd0 || tile_h_q == 5'd1);
		n_res = 1'b0;
		if (pix_done) begin
			acc_d = pix_val;
			bif_d = 2'd0;
		end else begin
			acc_d = pix_acc;
			bif_d = bif_q + 2'd1;
		end
		unique case (ph_q)
			PH_BG: begin
				if (pix_done) begin
					bg_d = pix_val;
					do_bg = 1'b1;
				end
			end
			PH_FG: begin
				if (pix_done) begin
					fg_d = pix_val;
					if (flags_q[3]) ph_d = PH_COUNT;
					else do_end = 1'b1;
				end
			end
			PH_COUNT: begin
				left_d = byte_in;
				bif_d  = 2'd0;
				acc_d  = acc_q;
				if (byte_in == 8'd0) do_end = 1'b1;
				else ph_d = flags_q[4] ? PH_SUBCOLOR : PH_SUBXY;
			end
			PH_SUBCOLOR: begin
				if (pix_done) begin
					scol_d = pix_val;
					ph_d = PH_SUBXY;
				end
			end
			PH_SUBXY: begin
				sxy_d = byte_in;
				ph_d = PH_SUBWH;
				bif_d = bif_q;
				acc_d = acc_q;
			end
			PH_SUBWH: begin
				bif_d = 2'd0;
				acc_d = acc_q;
				o0.kind  = KIND_BOX;
				o0.pos_x = tile_x_q + {12'd0, sxy_q[7:4]};
				o0.pos_y = tile_y_q + {12'd0, sxy_q[3:0]};
				o0.box_w = {1'b0, byte_in[7:4]} + 5'd1;
				o0.box_h = {1'b0, byte_in[3:0]} + 5'd1;
				o0.color = flags_q[4] ? scol_q : fg_q;
				cnt = 2'd1;
				left_d = left_m1;
				if (left_m1 == 8'd0) do_end = 1'b1;
				else ph_d = flags_q[4] ? PH_SUBCOLOR : PH_SUBXY;
			end
			PH_RAW: begin
				if (pix_done) begin
					o0.kind  = KIND_RAW;
					o0.pos_x = tile_x_q + {12'd0, rcol_q};
					o0.pos_y = tile_y_q + {12'd0, rrow_q};
					o0.box_w = 5'd1;
					o0.box_h = 5'd1;
					o0.color = pix_val;
					cnt = 2'd1;
					if (raw_last) begin
						do_end = 1'b1;
					end else if (rcol_q == tile_w_q[3:0] - 4'd1 || tile_w_q <= 5'd1) begin
						rcol_d = 4'd0;
						rrow_d = rrow_q + 4'd1;
					end else begin
						rcol_d = rcol_q + 4'd1;
					end
				end
			end
			default: begin
				flags_d = nflags;
				bif_d = 2'd0;
				acc_d = acc_q;
				rcol_d = 4'd0;
				rrow_d = 4'd0;
				if (nflags[0]) ph_d = PH_RAW;
				else if (nflags[1]) ph_d = PH_BG;
				else do_bg = 1'b1;
			end
		endcase
		// Background box, then foreground, subrectangle count or tile end
		if (do_bg) begin
			o0.kind  = KIND_BOX;
			o0.pos_x = tile_x_q;
			o0.pos_y = tile_y_q;
			o0.box_w = tile_w_q;
			o0.box_h = tile_h_q;
			o0.color = bg_d;
			cnt = 2'd1;
			if (flags_d[2]) begin
				ph_d = PH_FG;
				bif_d = 2'd0;
			end else if (flags_d[3]) begin
				ph_d = PH_COUNT;
			end else begin
				do_end = 1'b1;
			end
		end
		// Step to the next tile; emit done after the last
		if (do_end) begin
			ph_d = PH_SUBENC;
			bif_d = 2'd0;
			rcol_d = 4'd0;
			rrow_d = 4'd0;
			left_d = 8'd0;
			if ({1'b0, endx} < {2'b00, wv}) begin
				tile_x_d = tile_x_q + TS16;
				tile_w_d = remw;
			end else begin
				tile_x_d = rect_x_q;
				tile_w_d = clipw;
				if ({1'b0, endy} < {2'b00, hv}) begin
					tile_y_d = tile_y_q + TS16;
					tile_h_d = remh;
				end else begin
					tile_y_d = rect_y_q;
					tile_h_d = cliph;
					if (cnt == 2'd0) begin
						o0.kind = KIND_DONE;
						cnt = 2'd1;
					end else begin
						o1.kind = KIND_DONE;
						cnt = 2'd2;
					end
				end
			end
		end
		n_res = (cnt == 2'd2);
		if (cnt == 2'd2) o1.last = 1'b1;
		else o0.last = 1'b1;
	end

	// Configuration and parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_x_q <= '0; rect_y_q <= '0; rect_w_q <= 16'd1; rect_h_q <= 16'd1;
			psize_q <= '0; bigend_q <= 1'b0;
			tile_x_q <= '0; tile_y_q <= '0; tile_w_q <= 5'd1; tile_h_q <= 5'd1;
			flags_q <= '0; bg_q <= '0; fg_q <= '0; acc_q <= '0; scol_q <= '0;
			left_q <= '0; sxy_q <= '0; ph_q <= PH_SUBENC; bif_q <= '0;
			rcol_q <= '0; rrow_q <= '0;
			res_vld <= 1'b0;
		end else begin
			res_vld <= byte_vld && (cnt != 2'd0);
			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_RECT_X: rect_x_q <= cfg_val;
					REG_RECT_Y: rect_y_q <= cfg_val;
					REG_RECT_W: rect_w_q <= cfg_val;
					REG_RECT_H: rect_h_q <= cfg_val;
					REG_PSIZE:  psize_q  <= cfg_val[1:0];
					REG_BIGEND: bigend_q <= cfg_val[0];
					default: ;
				endcase
				if (cfg_idx <= REG_RECT_H) begin
					tile_x_q <= (cfg_idx == REG_RECT_X) ? cfg_val : rect_x_q;
					tile_y_q <= (cfg_idx == REG_RECT_Y) ? cfg_val : rect_y_q;
					tile_w_q <= clip5({1'b0, (cfg_idx == REG_RECT_W) ?
						((cfg_val == 16'd0) ? 16'd1 : cfg_val) : wv});
					tile_h_q <= clip5({1'b0, (cfg_idx == REG_RECT_H) ?
						((cfg_val == 16'd0) ? 16'd1 : cfg_val) : hv});
					ph_q <= PH_SUBENC; bif_q <= '0; rcol_q <= '0; rrow_q <= '0;
					left_q <= '0;
				end
			end else if (byte_vld) begin
				tile_x_q <= tile_x_d; tile_y_q <= tile_y_d;
				tile_w_q <= tile_w_d; tile_h_q <= tile_h_d;
				flags_q <= flags_d; bg_q <= bg_d; fg_q <= fg_d; acc_q <= acc_d;
				scol_q <= scol_d; left_q <= left_d; sxy_q <= sxy_d; ph_q <= ph_d;
				bif_q <= bif_d; rcol_q <= rcol_d; rrow_q <= rrow_d;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (byte_vld) begin
			res.two <= n_res;
			res.r0  <= o0;
			res.r1  <= o1;
		end
	end

	`HRD_ASSERT_IMP(a_ph_legal, clk, arst_n, 1'b1, ph_q <= PH_RAW, "bad parse phase")
	`HRD_ASSERT_IMP(a_tile_w, clk, arst_n, 1'b1,
		tile_w_q != 5'd0 && tile_w_q <= TS16[4:0], "tile width out of range")
	`HRD_ASSERT_IMP(a_raw_pos, clk, arst_n, ph_q == PH_RAW,
		{1'b0, rcol_q} < tile_w_q, "raw column past tile")
endmodule

@@ tb/tb.sv @@
//------------------------------------------------------------------------------
// tb
// Self-checking bench for the hextile rectangle decoder. The bench feeds
// directed and random hextile tile streams and predicts every box fill, raw
// pixel and rectangle-done result. It compares each result field by field
// under several sender idle and receiver stall patterns.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
	import hrd_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	hextile_rect_decoder_core dut (.*);

	// Generate a 10 ns clock
	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned bytes_sent = 0;
	int unsigned results_seen = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	result_t expected_q[$];

	// Decoder model state
	logic [15:0] m_rx, m_ry, m_rw, m_rh;
	logic [1:0]  m_psz;
	logic        m_bend;
	logic [15:0] t_x, t_y;
	logic [4:0]  t_w, t_h, flags;
	logic [31:0] bg, fg, sub_col, acc;
	logic [7:0]  left, sub_xy, raw_idx;
	logic [3:0]  phase;
	logic [1:0]  bif;

	function automatic int unsigned eff_dim(logic [15:0] v);
		return (v == 16'd0) ? 1 : int'(v);
	endfunction

	function automatic logic [4:0] clip16(int unsigned v);
		return (v < 16) ? 5'(v) : 5'd16;
	endfunction

	function automatic int unsigned pix_bytes();
		return (m_psz == 2'd0) ? 1 : (m_psz == 2'd1) ? 2 : 4;
	endfunction

	task automatic rewind_walk();
		t_x = m_rx;
		t_y = m_ry;
		t_w = clip16(eff_dim(m_rw));
		t_h = clip16(eff_dim(m_rh));
	endtask

	task automatic push_result(logic [1:0] k, logic [15:0] x, logic [15:0] y,
			logic [4:0] w, logic [4:0] h, logic [31:0] c);
		result_t r;
		r.kind = k; r.pos_x = x; r.pos_y = y; r.box_w = w; r.box_h = h;
		r.color = c; r.last = 1'b0;
		expected_q.push_back(r);
	endtask

	// Advance to the next tile; emit done after the last one
	task automatic close_tile();
		int unsigned wv, hv, ox, oy;
		wv = eff_dim(m_rw);
		hv = eff_dim(m_rh);
		ox = 16'(t_x - m_rx);
		oy = 16'(t_y - m_ry);
		phase = PH_SUBENC; bif = 0; raw_idx = 0; left = 0;
		if (ox + 16 < wv) begin
			t_x = t_x + 16'd16;
			t_w = clip16(wv - ox - 16);
			return;
		end
		t_x = m_rx;
		t_w = clip16(wv);
		if (oy + 16 < hv) begin
			t_y = t_y + 16'd16;
			t_h = clip16(hv - oy - 16);
			return;
		end
		rewind_walk();
		push_result(KIND_DONE, 0, 0, 0, 0, 0);
	endtask

	task automatic take_pixel_byte(logic [7:0] b, output bit done, output logic [31:0] val);
		int unsigned nb, idx;
		nb = pix_bytes();
		idx = bif;
		done = 0;
		val = 0;
		if (idx == 0) acc = 0;
		if (m_bend) acc = {acc[23:0], b};
		else acc = acc | (32'(b) << (8 * idx));
		if (idx + 1 >= nb) begin
			bif = 0;
			val = (nb == 4) ? acc : (acc & ((32'd1 << (8 * nb)) - 1));
			done = 1;
		end else begin
			bif = 2'(idx + 1);
		end
	endtask

	task automatic after_fg();
		if (flags[3]) phase = PH_COUNT;
		else close_tile();
	endtask

	task automatic after_bg();
		push_result(KIND_BOX, t_x, t_y, t_w, t_h, bg);
		if (flags[2]) begin
			phase = PH_FG;
			bif = 0;
		end else begin
			after_fg();
		end
	endtask

	task automatic next_subrect();
		phase = flags[4] ? PH_SUBCOLOR : PH_SUBXY;
		bif = 0;
	endtask

	// Predict the results caused by one accepted stream byte
	task automatic predict_byte(logic [7:0] b);
		int n0;
		bit done;
		logic [31:0] val;
		int unsigned w, cnt;
		n0 = expected_q.size();
		case (phase)
			PH_BG: begin
				take_pixel_byte(b, done, val);
				if (done) begin bg = val; after_bg(); end
			end
			PH_FG: begin
				take_pixel_byte(b, done, val);
				if (done) begin fg = val; after_fg(); end
			end
			PH_COUNT: begin
				left = b;
				if (b == 0) close_tile();
				else next_subrect();
			end
			PH_SUBCOLOR: begin
				take_pixel_byte(b, done, val);
				if (done) begin sub_col = val; phase = PH_SUBXY; end
			end
			PH_SUBXY: begin
				sub_xy = b;
				phase = PH_SUBWH;
			end
			PH_SUBWH: begin
				push_result(KIND_BOX, t_x + 16'(sub_xy[7:4]), t_y + 16'(sub_xy[3:0]),
					5'(b[7:4]) + 5'd1, 5'(b[3:0]) + 5'd1, flags[4] ? sub_col : fg);
				left = left - 8'd1;
				if (left == 0) close_tile();
				else next_subrect();
			end
			PH_RAW: begin
				take_pixel_byte(b, done, val);
				if (done) begin
					w = (t_w == 0) ? 1 : t_w;
					cnt = w * ((t_h == 0) ? 1 : t_h);
					push_result(KIND_RAW, t_x + 16'(raw_idx % w), t_y + 16'(raw_idx / w),
						5'd1, 5'd1, val);
					if (raw_idx + 1 >= cnt) close_tile();
					else raw_idx = raw_idx + 8'd1;
				end
			end
			default: begin
				flags = b[4:0];
				bif = 0;
				raw_idx = 0;
				if (flags[0]) phase = PH_RAW;
				else if (flags[1]) phase = PH_BG;
				else after_bg();
			end
		endcase
		if (expected_q.size() > n0) expected_q[$].last = 1'b1;
	endtask

	// Hold a byte until accepted, with random idle gaps before it
	task automatic send_byte(logic [7:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		predict_byte(b);
		bytes_sent++;
	endtask

	// Wait for every result, then let the pipeline settle
	task automatic drain();
		s_tvalid <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [15:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_RECT_X: m_rx = d;
			REG_RECT_Y: m_ry = d;
			REG_RECT_W: m_rw = d;
			REG_RECT_H: m_rh = d;
			REG_PSIZE:  m_psz = d[1:0];
			REG_BIGEND: m_bend = d[0];
			default: ;
		endcase
		if (idx <= REG_RECT_H) begin
			rewind_walk();
			phase = PH_SUBENC; bif = 0; raw_idx = 0; left = 0;
		end
	endtask

	task automatic set_config(logic [15:0] x, logic [15:0] y, logic [15:0] w,
			logic [15:0] h, logic [1:0] psz, logic be);
		drain();
		cfg_write(REG_RECT_X, x);
		cfg_write(REG_RECT_Y, y);
		cfg_write(REG_RECT_W, w);
		cfg_write(REG_RECT_H, h);
		cfg_write(REG_PSIZE, 16'(psz));
		cfg_write(REG_BIGEND, 16'(be));
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel();
		repeat (pix_bytes()) send_byte(8'($urandom));
	endtask

	// Send one well-formed tile for the current tile size and format
	task automatic send_tile();
		logic [7:0] sub, cnt;
		int unsigned npix;
		sub = 8'($urandom);
		if ($urandom_range(3) != 0) sub[0] = 1'b0;
		npix = ((t_w == 0) ? 1 : t_w) * ((t_h == 0) ? 1 : t_h);
		// Keep raw tiles to small edge tiles so the byte count stays moderate
		if (npix * pix_bytes() > 64) sub[0] = 1'b0;
		send_byte(sub);
		if (sub[0]) begin
			repeat (npix) send_pixel();
			return;
		end
		if (sub[1]) send_pixel();
		if (sub[2]) send_pixel();
		if (sub[3]) begin
			cnt = ($urandom_range(15) == 0) ? 8'd0 : 8'($urandom_range(1, 5));
			send_byte(cnt);
			repeat (cnt) begin
				if (sub[4]) send_pixel();
				send_byte(8'($urandom));
				send_byte(8'($urandom));
			end
		end
	endtask

	// Directed bytes: every subencoding path on a 1x1 rectangle
	task automatic test_directed();
		logic [7:0] seq[] = '{8'h00, 8'h02, 8'hAB, 8'hE0, 8'h10, 8'h01, 8'hFF,
			8'h0E, 8'h11, 8'h22, 8'h00, 8'h1A, 8'h33, 8'h01, 8'h44, 8'hFF, 8'hFF,
			8'h0C, 8'h55, 8'h02, 8'h00, 8'h00, 8'hF0, 8'h0F};
		set_config(0, 0, 1, 1, 0, 0);
		foreach (seq[i]) send_byte(seq[i]);
	endtask

	// Extremes: zero size, coordinate wrap, size code three, largest rectangle
	task automatic test_edges();
		set_config(16'hFFF8, 16'hFFFF, 16'd0, 16'd20, 2'd1, 1'b1);
		repeat (3) send_tile();
		set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3, 1'b0);
		repeat (3) send_tile();
		set_config(16'h1234, 16'h0000, 16'd17, 16'd1, 2'd2, 1'b1);
		repeat (4) send_tile();
	endtask

	// Random rectangles and tiles under one idle and stall pattern, with some noise bytes
	task automatic test_random(int unsigned idle, int unsigned stall, int unsigned budget);
		int unsigned stop;
		drain();
		send_idle_pct = idle;
		recv_stall_pct = stall;
		stop = bytes_sent + budget;
		while (bytes_sent < stop) begin
			set_config(16'($urandom), 16'($urandom), 16'($urandom_range(0, 40)),
				16'($urandom_range(0, 24)), 2'($urandom_range(0, 3)), 1'($urandom));
			repeat ($urandom_range(1, 8)) begin
				if ($urandom_range(9) == 0) send_byte(8'($urandom));
				else send_tile();
			end
		end
	endtask

	// Receiver backpressure
	always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// Compare each result transaction with the oldest expected one
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			result_t e;
			results_seen++;
			if (expected_q.size() == 0) begin
				$error("unexpected result tdata=%h tlast=%b", m_tdata, m_tlast);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (m_tdata[1:0] !== e.kind) begin
					$error("kind exp %0d got %0d", e.kind, m_tdata[1:0]); errors++;
				end
				if (m_tdata[17:2] !== e.pos_x) begin
					$error("pos_x exp %0d got %0d", e.pos_x, m_tdata[17:2]); errors++;
				end
				if (m_tdata[33:18] !== e.pos_y) begin
					$error("pos_y exp %0d got %0d", e.pos_y, m_tdata[33:18]); errors++;
				end
				if (m_tdata[38:34] !== e.box_w) begin
					$error("box_w exp %0d got %0d", e.box_w, m_tdata[38:34]); errors++;
				end
				if (m_tdata[43:39] !== e.box_h) begin
					$error("box_h exp %0d got %0d", e.box_h, m_tdata[43:39]); errors++;
				end
				if (m_tdata[75:44] !== e.color) begin
					$error("color exp %h got %h", e.color, m_tdata[75:44]); errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last exp %0d got %0d", e.last, m_tlast); errors++;
				end
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tdata = 8'd0; m_tready = 1'b0;
		cfg_valid = 1'b0; cfg_index = REG_RECT_X; cfg_data = 16'd0;
		m_rx = 0; m_ry = 0; m_rw = 1; m_rh = 1; m_psz = 0; m_bend = 0;
		flags = 0; bg = 0; fg = 0; sub_col = 0; acc = 0; left = 0; sub_xy = 0;
		raw_idx = 0; phase = PH_SUBENC; bif = 0;
		rewind_walk();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_edges();
		test_random(0, 0, 110);
		test_random(79, 0, 110);
		test_random(0, 79, 110);
		test_random(36, 36, 110);
		drain();
		$display("tb: %0d stream bytes sent, %0d results checked over", bytes_sent,
			results_seen);
		$display("tb: raw, fill and subrectangle tiles, all formats and idle patterns");
		if (errors == 0) $display("tb: clean");
		else $display("tb: errors");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/hrd_pkg.sv
rtl/core/hrd_out_queue.sv
rtl/core/hrd_parser.sv
rtl/core/hextile_rect_decoder_core.sv
tb/tb.sv
